### hdl/jsd_pkg.sv
// Shared types, codes and helper functions of the JSON string literal decoder.
package jsd_pkg;

  localparam int unsigned MaxRes = 4;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERR   = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_QUOTE     = 4'd1,
    ERR_UNTERM    = 4'd2,
    ERR_CONTROL   = 4'd3,
    ERR_UTF8      = 4'd4,
    ERR_ESCAPE    = 4'd5,
    ERR_HEX       = 4'd6,
    ERR_SURROGATE = 4'd7,
    ERR_UNPRINT   = 4'd8
  } err_e;

  typedef struct packed {
    err_e       err;
    logic [7:0] data;
    kind_e      kind;
  } res_t;

  typedef struct packed {
    logic [2:0]        cnt;
    res_t [MaxRes-1:0] res;
  } bundle_t;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;

  function automatic bundle_t put_one(input kind_e k, input logic [7:0] d, input err_e e);
    bundle_t b;
    b = '0;
    b.cnt = 3'd1;
    b.res[0].kind = k;
    b.res[0].data = d;
    b.res[0].err = e;
    return b;
  endfunction

  function automatic res_t data_res(input logic [7:0] d);
    res_t r;
    r.kind = KIND_BYTE;
    r.data = d;
    r.err = ERR_NONE;
    return r;
  endfunction

  function automatic bundle_t put_cp(input logic [20:0] cp);
    bundle_t b;
    b = '0;
    if (cp < 21'h80) begin
      b.cnt = 3'd1;
      b.res[0] = data_res(cp[7:0]);
    end else if (cp < 21'h800) begin
      b.cnt = 3'd2;
      b.res[0] = data_res({3'b110, cp[10:6]});
      b.res[1] = data_res({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      b.cnt = 3'd3;
      b.res[0] = data_res({4'b1110, cp[15:12]});
      b.res[1] = data_res({2'b10, cp[11:6]});
      b.res[2] = data_res({2'b10, cp[5:0]});
    end else begin
      b.cnt = 3'd4;
      b.res[0] = data_res({5'b11110, cp[20:18]});
      b.res[1] = data_res({2'b10, cp[17:12]});
      b.res[2] = data_res({2'b10, cp[11:6]});
      b.res[3] = data_res({2'b10, cp[5:0]});
    end
    return b;
  endfunction

  function automatic logic unprintable(input logic [20:0] cp);
    return (cp < 21'h20) || (cp == 21'h7F) || ((cp >= 21'h80) && (cp < 21'hA0));
  endfunction

  // {valid, digit}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

### hdl/jsd_core.sv
// Decoder state and per-word step logic producing up to four result words.
module jsd_core
  import jsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       eot_i,
  input  logic       printable_i,
  output bundle_t    bundle_o
);

  typedef enum logic [8:0] {
    PH_AWAIT   = 9'b000000001,
    PH_SKIP    = 9'b000000010,
    PH_BODY    = 9'b000000100,
    PH_UTF8    = 9'b000001000,
    PH_ESC     = 9'b000010000,
    PH_HEX1    = 9'b000100000,
    PH_SURR_BS = 9'b001000000,
    PH_SURR_U  = 9'b010000000,
    PH_HEX2    = 9'b100000000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;
  logic [20:0] acc_q, acc_d;
  logic [9:0]  hi_q, hi_d;
  logic [1:0]  need_q, need_d;
  logic [1:0]  got_q, got_d;
  logic [7:0]  seq_q [MaxRes];

  logic        seq_we;
  logic [1:0]  seq_idx;
  logic        fail_en;
  err_e        fail_code;
  logic        cp_en;
  logic [20:0] cp_val;
  bundle_t     bun;

  logic [4:0]  hex;
  logic [15:0] acc_hex;
  logic [1:0]  got_n;
  logic [20:0] acc_utf;
  logic [20:0] min_cp;

  assign hex     = hex_val(byte_i);
  assign acc_hex = {acc_q[11:0], hex[3:0]};
  assign got_n   = got_q + 2'd1;
  assign acc_utf = {acc_q[14:0], byte_i[5:0]};

  always_comb begin
    case (need_q)
      2'd1:    min_cp = 21'h80;
      2'd2:    min_cp = 21'h800;
      2'd3:    min_cp = 21'h10000;
      default: min_cp = '0;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    hex_cnt_d = hex_cnt_q;
    acc_d     = acc_q;
    hi_d      = hi_q;
    need_d    = need_q;
    got_d     = got_q;
    seq_we    = 1'b0;
    seq_idx   = '0;
    fail_en   = 1'b0;
    fail_code = ERR_NONE;
    cp_en     = 1'b0;
    cp_val    = '0;
    bun       = '0;

    case (phase_q)
      PH_AWAIT: begin
        if (eot_i || byte_i != ChQuote) begin
          fail_en = 1'b1;
          fail_code = ERR_QUOTE;
        end else begin
          phase_d = PH_BODY;
        end
      end
      PH_SKIP: begin
        if (eot_i) begin
          phase_d = PH_AWAIT;
        end else if (byte_i == ChQuote) begin
          phase_d = PH_BODY;
        end
      end
      PH_BODY: begin
        if (eot_i) begin
          fail_en = 1'b1;
          fail_code = ERR_UNTERM;
        end else if (byte_i == ChQuote) begin
          bun = put_one(KIND_CLOSE, 8'h00, ERR_NONE);
          phase_d = PH_AWAIT;
        end else if (byte_i < 8'h20) begin
          fail_en = 1'b1;
          fail_code = ERR_CONTROL;
        end else if (byte_i == ChBslash) begin
          phase_d = PH_ESC;
        end else if (byte_i < 8'h80) begin
          cp_en = 1'b1;
          cp_val = {13'b0, byte_i};
        end else if (byte_i < 8'hC2 || byte_i > 8'hF4) begin
          fail_en = 1'b1;
          fail_code = ERR_UTF8;
        end else begin
          need_d = (byte_i >= 8'hF0) ? 2'd3 : (byte_i >= 8'hE0) ? 2'd2 : 2'd1;
          got_d = '0;
          seq_we = 1'b1;
          seq_idx = '0;
          acc_d = {13'b0, byte_i & (8'h3F >> need_d)};
          phase_d = PH_UTF8;
        end
      end
      PH_UTF8: begin
        if (eot_i || byte_i[7:6] != 2'b10) begin
          fail_en = 1'b1;
          fail_code = ERR_UTF8;
        end else begin
          got_d = got_n;
          seq_we = 1'b1;
          seq_idx = got_n;
          acc_d = acc_utf;
          if (got_n >= need_q) begin
            if (acc_utf < min_cp || acc_utf > 21'h10FFFF ||
                (acc_utf >= 21'hD800 && acc_utf <= 21'hDFFF)) begin
              fail_en = 1'b1;
              fail_code = ERR_UTF8;
            end else if (printable_i && unprintable(acc_utf)) begin
              fail_en = 1'b1;
              fail_code = ERR_UNPRINT;
            end else begin
              bun.cnt = {1'b0, need_q} + 3'd1;
              for (int i = 0; i < MaxRes; i++) begin
                if (i < int'(need_q)) begin
                  bun.res[i] = data_res(seq_q[i]);
                end else if (i == int'(need_q)) begin
                  bun.res[i] = data_res(byte_i);
                end
              end
              phase_d = PH_BODY;
            end
          end
        end
      end
      PH_ESC: begin
        if (eot_i) begin
          fail_en = 1'b1;
          fail_code = ERR_UNTERM;
        end else begin
          case (byte_i)
            8'h22, 8'h5C, 8'h2F: begin
              cp_en = 1'b1;
              cp_val = {13'b0, byte_i};
            end
            8'h62: begin
              cp_en = 1'b1;
              cp_val = 21'h08;
            end
            8'h66: begin
              cp_en = 1'b1;
              cp_val = 21'h0C;
            end
            8'h6E: begin
              cp_en = 1'b1;
              cp_val = 21'h0A;
            end
            8'h72: begin
              cp_en = 1'b1;
              cp_val = 21'h0D;
            end
            8'h74: begin
              cp_en = 1'b1;
              cp_val = 21'h09;
            end
            8'h75: begin
              hex_cnt_d = '0;
              acc_d = '0;
              phase_d = PH_HEX1;
            end
            default: begin
              fail_en = 1'b1;
              fail_code = ERR_ESCAPE;
            end
          endcase
        end
      end
      PH_HEX1, PH_HEX2: begin
        if (eot_i || !hex[4]) begin
          fail_en = 1'b1;
          fail_code = ERR_HEX;
        end else begin
          acc_d = {5'b0, acc_hex};
          if (hex_cnt_q != 2'd3) begin
            hex_cnt_d = hex_cnt_q + 2'd1;
          end else begin
            hex_cnt_d = '0;
            if (phase_q == PH_HEX1) begin
              if (acc_hex[15:10] == 6'b110111) begin
                fail_en = 1'b1;
                fail_code = ERR_SURROGATE;
              end else if (acc_hex[15:10] == 6'b110110) begin
                hi_d = acc_hex[9:0];
                phase_d = PH_SURR_BS;
              end else begin
                cp_en = 1'b1;
                cp_val = {5'b0, acc_hex};
              end
            end else begin
              if (acc_hex[15:10] != 6'b110111) begin
                fail_en = 1'b1;
                fail_code = ERR_SURROGATE;
              end else begin
                cp_en = 1'b1;
                cp_val = {1'b0, hi_q, acc_hex[9:0]} + 21'h10000;
              end
            end
          end
        end
      end
      PH_SURR_BS: begin
        if (eot_i || byte_i != ChBslash) begin
          fail_en = 1'b1;
          fail_code = ERR_SURROGATE;
        end else begin
          phase_d = PH_SURR_U;
        end
      end
      PH_SURR_U: begin
        if (eot_i || byte_i != 8'h75) begin
          fail_en = 1'b1;
          fail_code = ERR_SURROGATE;
        end else begin
          hex_cnt_d = '0;
          acc_d = '0;
          phase_d = PH_HEX2;
        end
      end
      default: begin
        if (eot_i) begin
          fail_en = 1'b1;
          fail_code = ERR_SURROGATE;
        end else begin
          phase_d = PH_SKIP;
        end
      end
    endcase

    if (cp_en) begin
      if (printable_i && unprintable(cp_val)) begin
        fail_en = 1'b1;
        fail_code = ERR_UNPRINT;
      end else begin
        bun = put_cp(cp_val);
        phase_d = PH_BODY;
      end
    end
    if (fail_en) begin
      bun = put_one(KIND_ERR, 8'h00, fail_code);
      phase_d = eot_i ? PH_AWAIT : PH_SKIP;
    end
  end

  assign bundle_o = bun;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_AWAIT;
      hex_cnt_q <= '0;
      acc_q     <= '0;
      hi_q      <= '0;
      need_q    <= '0;
      got_q     <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      hex_cnt_q <= hex_cnt_d;
      acc_q     <= acc_d;
      hi_q      <= hi_d;
      need_q    <= need_d;
      got_q     <= got_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && seq_we) begin
      seq_q[seq_idx] <= byte_i;
    end
  end

endmodule

### hdl/jsd_out.sv
// Result register that holds one bundle of words and sends them out one per cycle while m_axis_tready is high.
module jsd_out
  import jsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  bundle_t     bundle_i,
  output logic        free_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  logic       vld_q, vld_d;
  bundle_t    bun_q;
  logic [1:0] idx_q, idx_d;
  res_t       cur;
  logic       at_last;
  logic       fire;

  assign cur     = bun_q.res[idx_q];
  assign at_last = ({1'b0, idx_q} + 3'd1) == bun_q.cnt;
  assign fire    = vld_q && m_axis_tready;
  assign free_o  = !vld_q || (m_axis_tready && at_last);

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {4'b0, cur.err, cur.data};
  assign m_axis_tuser  = cur.kind;
  assign m_axis_tlast  = at_last;

  always_comb begin
    vld_d = vld_q;
    idx_d = idx_q;
    if (fire) begin
      if (at_last) begin
        vld_d = 1'b0;
        idx_d = '0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
    if (load_i) begin
      vld_d = 1'b1;
      idx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bun_q <= bundle_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (bun_q.cnt != 3'd0) && (bun_q.cnt <= 3'd4))
    else $error("held bundle has an impossible word count");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> ({1'b0, idx_q} < bun_q.cnt))
    else $error("word index runs past bundle count");

  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && cur.kind != KIND_BYTE) |-> at_last)
    else $error("end marker or error word is not the last of its bundle");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("bundle loaded over words not yet sent");

endmodule

### hdl/json_string_literal_decoder.sv
// Top level of the JSON string literal decoder: input register, decoder, result register.
//
// Input stream (s_axis_*): one text byte per word; tuser set marks end of text.
// Output stream (m_axis_*): one result word per decoded byte, end marker or error;
// tuser gives the kind, tlast marks the last word caused by one input word.
// Config: cfg_we_i writes cfg_wdata_i into the printable-only flag; write it only
// while the block is idle.
// Path: an accepted word is held in the input register and is decoded into the result
// register when that register is free; its first result word is then offered on m_axis.
// Throughput: one input word per cycle while m_axis_tready is high and every word yields
// at most one result; a word yielding k results (raw or escaped multi-byte UTF-8, up to
// four) holds the result register until its last result is taken, since results leave one per cycle through m_axis.
// Reset: the decoder waits for an opening quote, printable-only is cleared, both
// registers are empty.
// Stall: when m_axis_tready is low the result register holds, the input register
// fills, and s_axis_tready drops; no word is lost or repeated.
module json_string_literal_decoder
  import jsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tuser,   // [0] end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [11:8] error_code, [15:12] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast
);

  logic       prn_q;
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_eot_q;
  logic       out_free;
  logic       step;
  bundle_t    bun;

  assign step          = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prn_q    <= 1'b0;
      in_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        prn_q <= cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_vld_q <= 1'b1;
      end else if (step) begin
        in_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_eot_q  <= s_axis_tuser;
    end
  end

  jsd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .eot_i       (in_eot_q),
    .printable_i (prn_q),
    .bundle_o    (bun)
  );

  jsd_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (step && (bun.cnt != 3'd0)),
    .bundle_i      (bun),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### bench/jsd_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the JSON string literal decoder: predicts result words and checks them in order.
module jsd_checker
  import jsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int unsigned fails_o,
  output int unsigned pend_o
);

  typedef enum logic [3:0] {
    ST_AWAIT,
    ST_SKIP,
    ST_BODY,
    ST_UTF8,
    ST_ESC,
    ST_HEX1,
    ST_SURR_BS,
    ST_SURR_U,
    ST_HEX2
  } scan_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    err_e       err;
    logic       last;
  } word_t;

  word_t       want_q[$];
  scan_e       scan;
  logic        print_only;
  logic [1:0]  nibbles;
  logic [20:0] acc;
  logic [9:0]  hi_half;
  logic [7:0]  seq_b[4];
  logic [1:0]  seq_need;
  logic [1:0]  seq_got;
  int unsigned fails = 0;

  assign fails_o = fails;

  task automatic flag(input string what);
    $display("jsd_checker: %s", what);
    fails++;
  endtask

  function automatic void want(input kind_e k, input logic [7:0] d, input err_e e);
    word_t w;
    w.kind = k;
    w.data = d;
    w.err = e;
    w.last = 1'b0;
    want_q = {want_q, w};
  endfunction

  function automatic void abort(input err_e e, input logic at_end);
    want(KIND_ERR, 8'h00, e);
    scan = at_end ? ST_AWAIT : ST_SKIP;
  endfunction

  function automatic logic ctl_point(input logic [20:0] cp);
    return cp < 21'h20 || cp == 21'h7F || (cp >= 21'h80 && cp < 21'hA0);
  endfunction

  function automatic void emit_point(input logic [20:0] cp);
    if (print_only && ctl_point(cp)) begin
      abort(ERR_UNPRINT, 1'b0);
      return;
    end
    if (cp < 21'h80) begin
      want(KIND_BYTE, cp[7:0], ERR_NONE);
    end else if (cp < 21'h800) begin
      want(KIND_BYTE, 8'hC0 | 8'(cp >> 6), ERR_NONE);
      want(KIND_BYTE, 8'h80 | 8'(cp & 21'h3F), ERR_NONE);
    end else if (cp < 21'h10000) begin
      want(KIND_BYTE, 8'hE0 | 8'(cp >> 12), ERR_NONE);
      want(KIND_BYTE, 8'h80 | 8'((cp >> 6) & 21'h3F), ERR_NONE);
      want(KIND_BYTE, 8'h80 | 8'(cp & 21'h3F), ERR_NONE);
    end else begin
      want(KIND_BYTE, 8'hF0 | 8'((cp >> 18) & 21'h7), ERR_NONE);
      want(KIND_BYTE, 8'h80 | 8'((cp >> 12) & 21'h3F), ERR_NONE);
      want(KIND_BYTE, 8'h80 | 8'((cp >> 6) & 21'h3F), ERR_NONE);
      want(KIND_BYTE, 8'h80 | 8'(cp & 21'h3F), ERR_NONE);
    end
    scan = ST_BODY;
  endfunction

  function automatic void consume(input logic [7:0] b, input logic eot);
    int unsigned base;
    logic        ok;
    logic [3:0]  nib;
    logic [15:0] v;
    logic [20:0] floor_cp;
    int          i;
    base = want_q.size();
    ok = 1'b1;
    nib = 4'd0;
    if (eot) begin
      case (scan)
        ST_AWAIT: abort(ERR_QUOTE, 1'b1);
        ST_SKIP: scan = ST_AWAIT;
        ST_BODY, ST_ESC: abort(ERR_UNTERM, 1'b1);
        ST_UTF8: abort(ERR_UTF8, 1'b1);
        ST_HEX1, ST_HEX2: abort(ERR_HEX, 1'b1);
        default: abort(ERR_SURROGATE, 1'b1);
      endcase
    end else begin
      case (scan)
        ST_AWAIT: begin
          if (b == ChQuote) scan = ST_BODY;
          else abort(ERR_QUOTE, 1'b0);
        end
        ST_SKIP: begin
          if (b == ChQuote) scan = ST_BODY;
        end
        ST_BODY: begin
          if (b == ChQuote) begin
            want(KIND_CLOSE, 8'h00, ERR_NONE);
            scan = ST_AWAIT;
          end else if (b < 8'h20) begin
            abort(ERR_CONTROL, 1'b0);
          end else if (b == ChBslash) begin
            scan = ST_ESC;
          end else if (b < 8'h80) begin
            emit_point({13'd0, b});
          end else if (b < 8'hC2 || b > 8'hF4) begin
            abort(ERR_UTF8, 1'b0);
          end else begin
            seq_need = (b >= 8'hF0) ? 2'd3 : (b >= 8'hE0) ? 2'd2 : 2'd1;
            seq_got = 2'd0;
            seq_b[0] = b;
            acc = {13'd0, b & (8'h3F >> seq_need)};
            scan = ST_UTF8;
          end
        end
        ST_UTF8: begin
          if (b[7:6] != 2'b10) begin
            abort(ERR_UTF8, 1'b0);
          end else begin
            seq_got = seq_got + 2'd1;
            seq_b[seq_got] = b;
            acc = {acc[14:0], b[5:0]};
            if (seq_got >= seq_need) begin
              floor_cp = (seq_need == 2'd1) ? 21'h80 : (seq_need == 2'd2) ? 21'h800 : 21'h10000;
              if (acc < floor_cp || acc > 21'h10FFFF || (acc >= 21'hD800 && acc <= 21'hDFFF)) begin
                abort(ERR_UTF8, 1'b0);
              end else if (print_only && ctl_point(acc)) begin
                abort(ERR_UNPRINT, 1'b0);
              end else begin
                for (i = 0; i <= seq_need; i++) want(KIND_BYTE, seq_b[i], ERR_NONE);
                scan = ST_BODY;
              end
            end
          end
        end
        ST_ESC: begin
          case (b)
            ChQuote: emit_point(21'h22);
            ChBslash: emit_point(21'h5C);
            "/": emit_point(21'h2F);
            "b": emit_point(21'h08);
            "f": emit_point(21'h0C);
            "n": emit_point(21'h0A);
            "r": emit_point(21'h0D);
            "t": emit_point(21'h09);
            "u": begin
              nibbles = 2'd0;
              acc = 21'd0;
              scan = ST_HEX1;
            end
            default: abort(ERR_ESCAPE, 1'b0);
          endcase
        end
        ST_HEX1, ST_HEX2: begin
          if (b >= "0" && b <= "9") nib = 4'(b - "0");
          else if (b >= "a" && b <= "f") nib = 4'(b - "a" + 8'd10);
          else if (b >= "A" && b <= "F") nib = 4'(b - "A" + 8'd10);
          else ok = 1'b0;
          if (!ok) begin
            abort(ERR_HEX, 1'b0);
          end else begin
            acc = {5'd0, acc[11:0], nib};
            if (nibbles != 2'd3) begin
              nibbles = nibbles + 2'd1;
            end else begin
              nibbles = 2'd0;
              v = acc[15:0];
              if (scan == ST_HEX1) begin
                if (v >= 16'hDC00 && v <= 16'hDFFF) begin
                  abort(ERR_SURROGATE, 1'b0);
                end else if (v >= 16'hD800 && v <= 16'hDBFF) begin
                  hi_half = 10'(v - 16'hD800);
                  scan = ST_SURR_BS;
                end else begin
                  emit_point({5'd0, v});
                end
              end else if (v < 16'hDC00 || v > 16'hDFFF) begin
                abort(ERR_SURROGATE, 1'b0);
              end else begin
                emit_point(21'h10000 + {1'b0, hi_half, 10'd0} + 21'(v - 16'hDC00));
              end
            end
          end
        end
        ST_SURR_BS: begin
          if (b == ChBslash) scan = ST_SURR_U;
          else abort(ERR_SURROGATE, 1'b0);
        end
        ST_SURR_U: begin
          if (b == "u") begin
            nibbles = 2'd0;
            acc = 21'd0;
            scan = ST_HEX2;
          end else begin
            abort(ERR_SURROGATE, 1'b0);
          end
        end
        default: scan = ST_SKIP;
      endcase
    end
    if (want_q.size() > base) want_q[want_q.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    word_t got;
    if (!rst_ni) begin
      want_q.delete();
      scan = ST_AWAIT;
      print_only = 1'b0;
      nibbles = 2'd0;
      acc = 21'd0;
      hi_half = 10'd0;
      seq_b = '{default: 8'h00};
      seq_need = 2'd0;
      seq_got = 2'd0;
      pend_o <= 0;
    end else begin
      if (cfg_we_i) print_only = cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) begin
        if (want_q.size() == 0) begin
          flag($sformatf("unexpected word: tuser %0d tdata %h tlast %b",
                         m_axis_tuser, m_axis_tdata, m_axis_tlast));
        end else begin
          got = want_q.pop_front();
          if (m_axis_tuser !== got.kind)
            flag($sformatf("kind %0d, want %0d", m_axis_tuser, got.kind));
          if (m_axis_tdata[7:0] !== got.data)
            flag($sformatf("out_byte %h, want %h", m_axis_tdata[7:0], got.data));
          if (m_axis_tdata[11:8] !== got.err)
            flag($sformatf("error_code %0d, want %0d", m_axis_tdata[11:8], got.err));
          if (m_axis_tdata[15:12] !== 4'd0)
            flag($sformatf("tdata pad bits %h, want 0", m_axis_tdata[15:12]));
          if (m_axis_tlast !== got.last)
            flag($sformatf("tlast %b, want %b", m_axis_tlast, got.last));
        end
      end
      if (s_axis_tvalid && s_axis_tready) consume(s_axis_tdata, s_axis_tuser);
      pend_o <= want_q.size();
    end
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Testbench top for the JSON string literal decoder: clock, reset, stimulus, flow control, verdict.
module tb;
  import jsd_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] text_byte
  logic        s_axis_tuser = 1'b0;   // [0] end_of_text
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;          // [7:0] out_byte, [11:8] error_code, [15:12] zero
  logic [1:0]  m_axis_tuser;          // [1:0] kind
  logic        m_axis_tlast;

  int unsigned fails;
  int unsigned pending;
  int unsigned tx_idle = 0;
  int unsigned rx_idle = 0;
  int unsigned words_sent = 0;
  int unsigned hold_reqs = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;

  json_string_literal_decoder u_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  jsd_checker u_chk (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast,
    .fails_o(fails),
    .pend_o(pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // hold tready low for a long stretch on request, else idle at random
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != hold_reqs) begin
      m_axis_tready <= 1'b0;
      hold_left <= 200;
      holds_done <= holds_done + 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  initial begin
    #2_000_000;
    $display("tb: done, errors");
    $finish;
  end

  task automatic send_word(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= eot;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic put_eot();
    send_word(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic write_cfg(input logic v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  function automatic logic [7:0] hex_digit(input logic [3:0] d);
    if (d < 4'd10) return "0" + d;
    return ($urandom_range(1) ? "A" : "a") + d - 8'd10;
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'($urandom_range(8'hBF, 8'h80));
  endfunction

  // random non-surrogate code point of a given UTF-8 length, biased to the range ends
  function automatic logic [20:0] pick_cp(input int unsigned len);
    logic [20:0] lo;
    logic [20:0] hi;
    logic [20:0] cp;
    lo = (len == 1) ? 21'h0 : (len == 2) ? 21'h80 : (len == 3) ? 21'h800 : 21'h10000;
    hi = (len == 1) ? 21'h7F : (len == 2) ? 21'h7FF : (len == 3) ? 21'hFFFF : 21'h10FFFF;
    case ($urandom_range(5))
      0: cp = lo;
      1: cp = hi;
      default: cp = 21'($urandom_range(hi, lo));
    endcase
    if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h3000;
    return cp;
  endfunction

  task automatic send_u16(input logic [15:0] v);
    send_word(ChBslash, 1'b0);
    send_word("u", 1'b0);
    for (int k = 3; k >= 0; k--) send_word(hex_digit(v[4*k +: 4]), 1'b0);
  endtask

  task automatic send_raw(input logic [20:0] cp);
    if (cp < 21'h80) begin
      send_word(cp[7:0], 1'b0);
    end else if (cp < 21'h800) begin
      send_word({3'b110, cp[10:6]}, 1'b0);
      send_word({2'b10, cp[5:0]}, 1'b0);
    end else if (cp < 21'h10000) begin
      send_word({4'b1110, cp[15:12]}, 1'b0);
      send_word({2'b10, cp[11:6]}, 1'b0);
      send_word({2'b10, cp[5:0]}, 1'b0);
    end else begin
      send_word({5'b11110, cp[20:18]}, 1'b0);
      send_word({2'b10, cp[17:12]}, 1'b0);
      send_word({2'b10, cp[11:6]}, 1'b0);
      send_word({2'b10, cp[5:0]}, 1'b0);
    end
  endtask

  task automatic send_pair(input logic [20:0] cp);
    logic [19:0] v;
    v = 20'(cp - 21'h10000);
    send_u16(16'hD800 + 16'(v[19:10]));
    send_u16(16'hDC00 + 16'(v[9:0]));
  endtask

  task automatic send_broken();
    logic [7:0] b;
    case ($urandom_range(10))
      0: send_word(8'($urandom_range(8'h1F)), 1'b0);
      1: begin
        b = 8'($urandom_range(255));
        if (b inside {ChQuote, ChBslash, "/", "b", "f", "n", "r", "t", "u"}) b = "x";
        send_word(ChBslash, 1'b0);
        send_word(b, 1'b0);
      end
      2: begin
        b = 8'($urandom_range(255));
        if (b inside {["0":"9"], ["a":"f"], ["A":"F"]}) b = "g";
        send_word(ChBslash, 1'b0);
        send_word("u", 1'b0);
        repeat ($urandom_range(3)) send_word(hex_digit(4'($urandom_range(15))), 1'b0);
        send_word(b, 1'b0);
      end
      3: send_u16(16'($urandom_range(16'hDFFF, 16'hDC00)));
      4: begin
        send_u16(16'($urandom_range(16'hDBFF, 16'hD800)));
        case ($urandom_range(2))
          0: send_word("a", 1'b0);
          1: begin
            send_word(ChBslash, 1'b0);
            send_word("n", 1'b0);
          end
          default: send_u16(16'($urandom_range(16'hDBFF, 16'h0000)));
        endcase
      end
      5: begin
        if ($urandom_range(1)) send_word(8'($urandom_range(8'hC1, 8'h80)), 1'b0);
        else send_word(8'($urandom_range(8'hFF, 8'hF5)), 1'b0);
      end
      6: begin
        send_word(8'($urandom_range(8'hF4, 8'hC2)), 1'b0);
        send_word({$urandom_range(1) ? 2'b00 : 2'b11, 6'($urandom_range(63))}, 1'b0);
      end
      7: begin
        if ($urandom_range(1)) begin
          send_word(8'hE0, 1'b0);
          send_word(8'($urandom_range(8'h9F, 8'h80)), 1'b0);
          send_word(cont_byte(), 1'b0);
        end else begin
          send_word(8'hF0, 1'b0);
          send_word(8'($urandom_range(8'h8F, 8'h80)), 1'b0);
          send_word(cont_byte(), 1'b0);
          send_word(cont_byte(), 1'b0);
        end
      end
      8: begin
        send_word(8'hED, 1'b0);
        send_word(8'($urandom_range(8'hBF, 8'hA0)), 1'b0);
        send_word(cont_byte(), 1'b0);
      end
      9: begin
        send_word(8'hF4, 1'b0);
        send_word(8'($urandom_range(8'hBF, 8'h90)), 1'b0);
        send_word(cont_byte(), 1'b0);
        send_word(cont_byte(), 1'b0);
      end
      default: begin
        case ($urandom_range(6))
          0: ;
          1: send_word(ChBslash, 1'b0);
          2: begin
            send_word(ChBslash, 1'b0);
            send_word("u", 1'b0);
            repeat ($urandom_range(3)) send_word(hex_digit(4'($urandom_range(15))), 1'b0);
          end
          3: send_word(8'($urandom_range(8'hF4, 8'hC2)), 1'b0);
          4: send_u16(16'($urandom_range(16'hDBFF, 16'hD800)));
          5: begin
            send_u16(16'($urandom_range(16'hDBFF, 16'hD800)));
            send_word(ChBslash, 1'b0);
          end
          default: begin
            send_u16(16'($urandom_range(16'hDBFF, 16'hD800)));
            send_word(ChBslash, 1'b0);
            send_word("u", 1'b0);
            send_word("D", 1'b0);
          end
        endcase
        put_eot();
      end
    endcase
  endtask

  task automatic send_token();
    int unsigned pick;
    logic [7:0]  b;
    pick = $urandom_range(99);
    if (pick < 30) begin
      b = 8'($urandom_range(8'h7E, 8'h20));
      if (b == ChQuote || b == ChBslash) b = "a";
      send_word(b, 1'b0);
    end else if (pick < 40) begin
      case ($urandom_range(7))
        0: b = ChQuote;
        1: b = ChBslash;
        2: b = "/";
        3: b = "b";
        4: b = "f";
        5: b = "n";
        6: b = "r";
        default: b = "t";
      endcase
      send_word(ChBslash, 1'b0);
      send_word(b, 1'b0);
    end else if (pick < 52) begin
      send_u16(16'(pick_cp($urandom_range(3, 1))));
    end else if (pick < 60) begin
      send_pair(pick_cp(4));
    end else if (pick < 80) begin
      send_raw(pick_cp($urandom_range(4, 2)));
    end else if (pick < 88) begin
      case ($urandom_range(2))
        0: send_word(8'h7F, 1'b0);
        1: send_raw(21'($urandom_range(8'h9F, 8'h80)));
        default: send_u16(16'($urandom_range(8'h9F)));
      endcase
    end else begin
      send_broken();
    end
  endtask

  task automatic send_string();
    send_word(ChQuote, 1'b0);
    repeat ($urandom_range(6, 1)) send_token();
    if ($urandom_range(15) == 0) put_eot();
    else send_word(ChQuote, 1'b0);
    case ($urandom_range(11))
      0: send_word(8'($urandom_range(255)), 1'b0);
      1: put_eot();
      default: ;
    endcase
  endtask

  task automatic send_strings(input int unsigned count);
    int unsigned stop;
    stop = words_sent + count;
    while (words_sent < stop) send_string();
    put_eot();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_cfg(1'b0);
    tx_idle = 33;
    rx_idle = 51;

    send_word(8'hFF, 1'b0);
    send_word(ChQuote, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(ChQuote, 1'b0);
    send_u16(16'h0000);
    send_raw(21'h10FFFF);
    send_pair(21'h1F600);
    send_word(ChQuote, 1'b0);
    put_eot();

    send_strings(110);

    settle();
    write_cfg(1'b1);
    tx_idle = 51;
    rx_idle = 33;
    send_strings(110);

    settle();
    write_cfg(1'b0);
    tx_idle = 0;
    rx_idle = 0;
    hold_reqs++;
    send_strings(110);

    settle();
    if (fails == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
